// ----- rtl/fhe_pkg.sv -----
`default_nettype none
package fhe_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int ENV_W      = 17;
  localparam int WORD_W     = 32;
  localparam int TWC_W      = 19;
  localparam int TWS_W      = 18;
  localparam int TW_W       = TWC_W + TWS_W;
  localparam int SQRT_STEPS = 32;
  localparam int STEP_W     = 5;
  localparam logic [ENV_W-1:0] ENV_MAX = 17'h1ffff;
  localparam logic [63:0]      PI_Q30  = 64'd3373259426;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PAD,
    ST_BR_RD,
    ST_BR_WA,
    ST_BR_WB,
    ST_BF_RD,
    ST_BF_MUL,
    ST_BF_TW,
    ST_BF_WA,
    ST_BF_WB,
    ST_MD_RD,
    ST_MD_WR,
    ST_RD_SQ,
    ST_RD_SUM,
    ST_RD_SQRT,
    ST_RD_OUT
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_READ,
    DP_MUL,
    DP_TWID,
    DP_WR_BFY_A,
    DP_WR_BFY_B,
    DP_WR_LOAD,
    DP_WR_ZERO,
    DP_WR_SWAP_A,
    DP_WR_SWAP_B,
    DP_WR_DOUBLE,
    DP_SQUARE,
    DP_SUM,
    DP_SQRT_STEP,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   inverse;
    logic   eof;
    logic   no_data;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // cos/sin of pi*j/2^s, Q1.17: {cos (signed 19b), sin (unsigned 18b)}
  function automatic logic [TW_W-1:0] twiddle_q17(input int unsigned j, input int unsigned s);
    logic [63:0] d, a, x, x2, ts, tc;
    logic signed [63:0] ss, sc, cq, sq, cr, sr, c, sn;
    logic neg, swp;
    d   = 64'd4 << s;
    a   = 64'd4 * 64'(j);
    neg = 1'b0;
    swp = 1'b0;
    if (a * 2 > d) begin
      a   = d - a;
      neg = 1'b1;
    end
    if (a * 4 > d) begin
      a   = (d >> 1) - a;
      swp = 1'b1;
    end
    x  = (PI_Q30 * a + (d >> 1)) >> (s + 2);
    x2 = (x * x) >> 30;
    ts = x;
    tc = 64'd1 << 30;
    ss = $signed(x);
    sc = $signed(64'd1 << 30);
    for (int n = 1; n <= 6; n++) begin
      case (n)
        1: begin ts = ((ts * x2) >> 30) / 6;   tc = ((tc * x2) >> 30) / 2;   end
        2: begin ts = ((ts * x2) >> 30) / 20;  tc = ((tc * x2) >> 30) / 12;  end
        3: begin ts = ((ts * x2) >> 30) / 42;  tc = ((tc * x2) >> 30) / 30;  end
        4: begin ts = ((ts * x2) >> 30) / 72;  tc = ((tc * x2) >> 30) / 56;  end
        5: begin ts = ((ts * x2) >> 30) / 110; tc = ((tc * x2) >> 30) / 90;  end
        default: begin ts = ((ts * x2) >> 30) / 156; tc = ((tc * x2) >> 30) / 132; end
      endcase
      if ((n % 2) == 1) begin
        ss = ss - $signed(ts);
        sc = sc - $signed(tc);
      end else begin
        ss = ss + $signed(ts);
        sc = sc + $signed(tc);
      end
    end
    cq = (sc < 0) ? 64'sd0 : sc;
    sq = (ss < 0) ? 64'sd0 : ss;
    cr = (cq + 64'sd4096) >>> 13;
    sr = (sq + 64'sd4096) >>> 13;
    c  = swp ? sr : cr;
    sn = swp ? cr : sr;
    if (neg) begin
      c = -c;
    end
    return {c[TWC_W-1:0], sn[TWS_W-1:0]};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/fhe_if.sv -----
`default_nettype none
interface fhe_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    opcode;
  logic signed [fhe_pkg::SAMPLE_W-1:0]     sample;
  logic                                    is_last;

  modport source (output valid, opcode, sample, is_last, input ready);
  modport sink   (input valid, opcode, sample, is_last, output ready);
endinterface

interface fhe_out_if;
  logic                            valid;
  logic                            ready;
  logic [fhe_pkg::ENV_W-1:0]       envelope;
  logic                            end_of_frame;
  logic                            no_data;

  modport source (output valid, envelope, end_of_frame, no_data, input ready);
  modport sink   (input valid, envelope, end_of_frame, no_data, output ready);
endinterface
`default_nettype wire

// ----- rtl/fhe_ctrl.sv -----
`default_nettype none
module fhe_ctrl #(
  parameter int AW = 10
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                opcode,
  input  wire logic                is_last,
  input  wire fhe_pkg::dp_status_t status,
  output fhe_pkg::dp_cmd_t         cmd,
  output logic [AW-1:0]            addr_a,
  output logic [AW-1:0]            addr_b,
  output logic [AW-2:0]            tw_idx
);
  import fhe_pkg::*;

  localparam int SW = (AW > 1) ? $clog2(AW) : 1;
  localparam int LW = $clog2(AW + 1);

  state_t           state, state_next;
  logic [AW-1:0]    cnt, cnt_next;
  logic [AW-1:0]    rp, rp_next;
  logic             fr, fr_next;
  logic [AW-1:0]    i, i_next;
  logic [AW-2:0]    b, b_next;
  logic [SW-1:0]    s, s_next;
  logic             pass_inv, pass_inv_next;
  logic [STEP_W-1:0] k, k_next;
  logic             rd_eof, rd_eof_next;
  logic             rd_nodata, rd_nodata_next;

  logic [LW-1:0]    lsz;
  logic [AW:0]      n_full;
  logic [AW-1:0]    nm1, hn;
  logic [AW-2:0]    hm1;
  logic [AW-1:0]    rev_full, rev;
  logic [AW-1:0]    bx, one_s, smask, bf_i, bf_ip;
  logic [AW-1:0]    load_idx, load_cnt;
  logic             br_done, bf_last_b, bf_last_s;

  always_comb begin
    lsz = '0;
    for (int q = 0; q < AW; q++) begin
      if (cnt[q]) lsz = LW'(q + 1);
    end
    n_full = (AW + 1)'(1) << lsz;
    nm1    = AW'(n_full - 1'b1);
    hn     = AW'(n_full >> 1);
    hm1    = (AW - 1)'((n_full >> 1) - 1'b1);
    for (int q = 0; q < AW; q++) begin
      rev_full[q] = i[AW-1-q];
    end
    rev      = rev_full >> (LW'(AW) - lsz);
    bx       = {1'b0, b};
    one_s    = AW'(1) << s;
    smask    = one_s - 1'b1;
    bf_i     = (((bx >> s) << s) << 1) | (bx & smask);
    bf_ip    = bf_i | one_s;
    tw_idx   = (AW - 1)'((bx & smask) << (SW'(AW - 1) - s));
    load_idx = (fr || (cnt == '1)) ? '0 : cnt;
    load_cnt = load_idx + 1'b1;
    br_done  = (AW'(i + 1'b1) == nm1);
    bf_last_b = (b == hm1);
    bf_last_s = (s == SW'(lsz - 1'b1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      rp        <= '0;
      fr        <= 1'b0;
      i         <= '0;
      b         <= '0;
      s         <= '0;
      pass_inv  <= 1'b0;
      k         <= '0;
      rd_eof    <= 1'b0;
      rd_nodata <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      rp        <= rp_next;
      fr        <= fr_next;
      i         <= i_next;
      b         <= b_next;
      s         <= s_next;
      pass_inv  <= pass_inv_next;
      k         <= k_next;
      rd_eof    <= rd_eof_next;
      rd_nodata <= rd_nodata_next;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    rp_next        = rp;
    fr_next        = fr;
    i_next         = i;
    b_next         = b;
    s_next         = s;
    pass_inv_next  = pass_inv;
    k_next         = k;
    rd_eof_next    = rd_eof;
    rd_nodata_next = rd_nodata;
    cmd            = '{op: DP_NOP, inverse: pass_inv, eof: rd_eof, no_data: rd_nodata};
    addr_a         = i;
    addr_b         = rev;
    in_ready       = 1'b0;

    unique case (state) inside
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (opcode == OP_LOAD) begin
            cmd.op   = DP_WR_LOAD;
            addr_a   = load_idx;
            cnt_next = load_cnt;
            fr_next  = 1'b0;
            rp_next  = '0;
            if (is_last || (load_cnt == '1)) begin
              i_next     = load_cnt;
              pass_inv_next = 1'b0;
              state_next = ST_PAD;
            end
          end else if (!fr) begin
            rd_nodata_next = 1'b1;
            rd_eof_next    = 1'b0;
            state_next     = ST_RD_OUT;
          end else begin
            rd_nodata_next = 1'b0;
            rd_eof_next    = ((AW + 1)'(rp) + 1'b1) >= (AW + 1)'(cnt);
            cmd.op         = DP_READ;
            addr_a         = rp;
            state_next     = ST_RD_SQ;
          end
        end
      end
      ST_PAD: begin
        cmd.op = DP_WR_ZERO;
        if (i == nm1) begin
          i_next     = '0;
          state_next = ST_BR_RD;
        end else begin
          i_next = i + 1'b1;
        end
      end
      ST_BR_RD, ST_BR_WA, ST_BR_WB: begin
        if (state == ST_BR_RD) cmd.op = DP_READ;
        else if (state == ST_BR_WA) cmd.op = DP_WR_SWAP_A;
        else cmd.op = DP_WR_SWAP_B;
        if ((state == ST_BR_RD) && (i < rev)) begin
          state_next = ST_BR_WA;
        end else if (state == ST_BR_WA) begin
          state_next = ST_BR_WB;
        end else if (br_done) begin
          i_next     = '0;
          b_next     = '0;
          s_next     = '0;
          state_next = ST_BF_RD;
        end else begin
          i_next     = i + 1'b1;
          state_next = ST_BR_RD;
        end
      end
      ST_BF_RD: begin
        cmd.op     = DP_READ;
        addr_a     = bf_i;
        addr_b     = bf_ip;
        state_next = ST_BF_MUL;
      end
      ST_BF_MUL: begin
        cmd.op     = DP_MUL;
        state_next = ST_BF_TW;
      end
      ST_BF_TW: begin
        cmd.op     = DP_TWID;
        state_next = ST_BF_WA;
      end
      ST_BF_WA: begin
        cmd.op     = DP_WR_BFY_A;
        addr_a     = bf_i;
        addr_b     = bf_ip;
        state_next = ST_BF_WB;
      end
      ST_BF_WB: begin
        cmd.op     = DP_WR_BFY_B;
        addr_a     = bf_i;
        addr_b     = bf_ip;
        state_next = ST_BF_RD;
        if (!bf_last_b) begin
          b_next = b + 1'b1;
        end else begin
          b_next = '0;
          if (!bf_last_s) begin
            s_next = s + 1'b1;
          end else if (!pass_inv) begin
            i_next     = AW'(1);
            state_next = ST_MD_RD;
          end else begin
            fr_next    = 1'b1;
            rp_next    = '0;
            state_next = ST_IDLE;
          end
        end
      end
      ST_MD_RD: begin
        cmd.op     = DP_READ;
        state_next = ST_MD_WR;
      end
      ST_MD_WR: begin
        cmd.op = (i < hn) ? DP_WR_DOUBLE : DP_WR_ZERO;
        if (i == nm1) begin
          i_next        = '0;
          pass_inv_next = 1'b1;
          state_next    = ST_BR_RD;
        end else begin
          i_next     = i + 1'b1;
          state_next = ST_MD_RD;
        end
      end
      ST_RD_SQ: begin
        cmd.op     = DP_SQUARE;
        state_next = ST_RD_SUM;
      end
      ST_RD_SUM: begin
        cmd.op     = DP_SUM;
        k_next     = '0;
        state_next = ST_RD_SQRT;
      end
      ST_RD_SQRT: begin
        cmd.op = DP_SQRT_STEP;
        k_next = k + 1'b1;
        if (k == STEP_W'(SQRT_STEPS - 1)) state_next = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        if (status.out_free) begin
          cmd.op     = DP_OUT;
          state_next = ST_IDLE;
          if (!rd_nodata) begin
            if (rd_eof) begin
              fr_next  = 1'b0;
              cnt_next = '0;
              rp_next  = '0;
            end else begin
              rp_next = rp + 1'b1;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/fhe_datapath.sv -----
`default_nettype none
module fhe_datapath #(
  parameter int AW = 10
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire fhe_pkg::dp_cmd_t                  cmd,
  input  wire logic [AW-1:0]                     addr_a,
  input  wire logic [AW-1:0]                     addr_b,
  input  wire logic [AW-2:0]                     tw_idx,
  input  wire logic signed [fhe_pkg::SAMPLE_W-1:0] sample,
  output fhe_pkg::dp_status_t                    status,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [fhe_pkg::ENV_W-1:0]              envelope,
  output logic                                   end_of_frame,
  output logic                                   no_data
);
  import fhe_pkg::*;

  localparam int DEPTH = 2 ** AW;
  localparam int HALF  = 2 ** (AW - 1);
  localparam int PW    = WORD_W + TWC_W;

  typedef logic [TW_W-1:0] tw_rom_t [HALF];

  function automatic tw_rom_t build_rom();
    tw_rom_t r;
    for (int q = 0; q < HALF; q++) begin
      r[q] = twiddle_q17(q, AW - 1);
    end
    return r;
  endfunction

  localparam tw_rom_t TW_ROM = build_rom();

  logic [2*WORD_W-1:0] mem [DEPTH];
  logic [2*WORD_W-1:0] rd_a, rd_b;
  logic [TW_W-1:0]     tw_q;

  logic signed [WORD_W-1:0] xr, xi, ar, ai, t_re, t_im;
  logic signed [TWC_W-1:0]  wr, wi;
  logic signed [PW-1:0]     p_rr, p_ii, p_ri, p_ir;
  logic signed [PW:0]       sum_r, sum_i;
  logic signed [WORD_W:0]   s_pr, s_pi, s_mr, s_mi;
  logic signed [WORD_W+1:0] h_pr, h_pi, h_mr, h_mi;
  logic [WORD_W-1:0]        v_pr, v_pi, v_mr, v_mi;
  logic [WORD_W-1:0]        ab_re, ab_im;
  logic [63:0]              sq_a, sq_b, rem, root, bitm, trial;

  logic                     we;
  logic [AW-1:0]            wa;
  logic [2*WORD_W-1:0]      wd;

  always_comb begin
    xr = $signed(rd_a[2*WORD_W-1:WORD_W]);
    xi = $signed(rd_a[WORD_W-1:0]);
    ar = $signed(rd_b[2*WORD_W-1:WORD_W]);
    ai = $signed(rd_b[WORD_W-1:0]);
    wr = $signed(tw_q[TW_W-1:TWS_W]);
    wi = cmd.inverse ? $signed({1'b0, tw_q[TWS_W-1:0]})
                     : -$signed({1'b0, tw_q[TWS_W-1:0]});
    sum_r = (PW + 1)'(p_rr) - (PW + 1)'(p_ii) + (PW + 1)'(65536);
    sum_i = (PW + 1)'(p_ri) + (PW + 1)'(p_ir) + (PW + 1)'(65536);
    s_pr = (WORD_W + 1)'(xr) + (WORD_W + 1)'(t_re);
    s_pi = (WORD_W + 1)'(xi) + (WORD_W + 1)'(t_im);
    s_mr = (WORD_W + 1)'(xr) - (WORD_W + 1)'(t_re);
    s_mi = (WORD_W + 1)'(xi) - (WORD_W + 1)'(t_im);
    h_pr = ((WORD_W + 2)'(s_pr) + (WORD_W + 2)'(1)) >>> 1;
    h_pi = ((WORD_W + 2)'(s_pi) + (WORD_W + 2)'(1)) >>> 1;
    h_mr = ((WORD_W + 2)'(s_mr) + (WORD_W + 2)'(1)) >>> 1;
    h_mi = ((WORD_W + 2)'(s_mi) + (WORD_W + 2)'(1)) >>> 1;
    v_pr = cmd.inverse ? h_pr[WORD_W-1:0] : s_pr[WORD_W-1:0];
    v_pi = cmd.inverse ? h_pi[WORD_W-1:0] : s_pi[WORD_W-1:0];
    v_mr = cmd.inverse ? h_mr[WORD_W-1:0] : s_mr[WORD_W-1:0];
    v_mi = cmd.inverse ? h_mi[WORD_W-1:0] : s_mi[WORD_W-1:0];
    ab_re = xr[WORD_W-1] ? WORD_W'(-xr) : WORD_W'(xr);
    ab_im = xi[WORD_W-1] ? WORD_W'(-xi) : WORD_W'(xi);
    trial = root + bitm;
  end

  always_comb begin
    we = 1'b1;
    wa = addr_a;
    wd = '0;
    case (cmd.op)
      DP_WR_LOAD:   wd = {WORD_W'(sample), {WORD_W{1'b0}}};
      DP_WR_ZERO:   wd = '0;
      DP_WR_SWAP_A: wd = rd_b;
      DP_WR_SWAP_B: begin
        wa = addr_b;
        wd = rd_a;
      end
      DP_WR_DOUBLE: wd = {xr[WORD_W-2:0], 1'b0, xi[WORD_W-2:0], 1'b0};
      DP_WR_BFY_A:  wd = {v_pr, v_pi};
      DP_WR_BFY_B: begin
        wa = addr_b;
        wd = {v_mr, v_mi};
      end
      default:      we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (cmd.op == DP_READ) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
      tw_q <= TW_ROM[tw_idx];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_MUL: begin
        p_rr <= ar * wr;
        p_ii <= ai * wi;
        p_ri <= ar * wi;
        p_ir <= ai * wr;
      end
      DP_TWID: begin
        t_re <= WORD_W'(sum_r >>> 17);
        t_im <= WORD_W'(sum_i >>> 17);
      end
      DP_SQUARE: begin
        sq_a <= 64'(ab_re) * 64'(ab_re);
        sq_b <= 64'(ab_im) * 64'(ab_im);
      end
      DP_SUM: begin
        rem  <= sq_a + sq_b;
        root <= '0;
        bitm <= 64'h4000_0000_0000_0000;
      end
      DP_SQRT_STEP: begin
        if (rem >= trial) begin
          rem  <= rem - trial;
          root <= (root >> 1) + bitm;
        end else begin
          root <= root >> 1;
        end
        bitm <= bitm >> 2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == DP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_OUT) begin
      if (cmd.no_data) envelope <= '0;
      else if (root > 64'(ENV_MAX)) envelope <= ENV_MAX;
      else envelope <= root[ENV_W-1:0];
      end_of_frame <= cmd.eof;
      no_data      <= cmd.no_data;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

// ----- rtl/fft_hilbert_envelope.sv -----
// Hilbert envelope of a frame of real Q1.15 samples.
// samples: valid/ready transactions; opcode 0 loads one sample, opcode 1
//   requests the next envelope value. is_last on a load closes the frame;
//   a frame reaching CAP-1 samples (CAP = largest power of two <= MAX_POINTS)
//   closes by itself.
// results: one transaction per read request: envelope (unsigned Q2.15,
//   saturated), end_of_frame on the frame's last sample, no_data when no
//   computed frame waits (envelope 0).
// Closing a frame of dn samples into N = 2^l points runs zero padding up to
//   N, a bit-reverse pass, the forward butterflies, spectrum shaping, a
//   second bit-reverse pass and the inverse butterflies. The work memory has
//   a single write port, and one butterfly unit steps through read, multiply,
//   twiddle, write A and write B.
// A read runs memory read, squares, sum, a 32-step square root and output;
//   a read with no frame waiting goes straight to output.
// Reset clears the control state; the work memory is not cleared.
// The output register holds a result until taken; while it is full the block
//   still takes loads, and a finished read waits for the register to drain.
`default_nettype none
module fft_hilbert_envelope #(
  parameter int MAX_POINTS = 1024
) (
  input wire logic clk,
  input wire logic rst,
  fhe_in_if.sink   samples,
  fhe_out_if.source results
);
  import fhe_pkg::*;

  localparam int AW = $clog2(MAX_POINTS + 1) - 1;

  dp_cmd_t        cmd;
  dp_status_t     status;
  logic [AW-1:0]  addr_a, addr_b;
  logic [AW-2:0]  tw_idx;

  fhe_ctrl #(.AW(AW)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .opcode   (samples.opcode),
    .is_last  (samples.is_last),
    .status   (status),
    .cmd      (cmd),
    .addr_a   (addr_a),
    .addr_b   (addr_b),
    .tw_idx   (tw_idx)
  );

  fhe_datapath #(.AW(AW)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .addr_a       (addr_a),
    .addr_b       (addr_b),
    .tw_idx       (tw_idx),
    .sample       (samples.sample),
    .status       (status),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .envelope     (results.envelope),
    .end_of_frame (results.end_of_frame),
    .no_data      (results.no_data)
  );

endmodule
`default_nettype wire

// ----- rtl/fhe_checker.sv -----
`default_nettype none
module fhe_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      opcode,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [fhe_pkg::ENV_W-1:0] envelope,
  input wire logic                      end_of_frame,
  input wire logic                      no_data
);
  import fhe_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  a_no_data_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_data |-> envelope == '0 && !end_of_frame)
    else $error("no_data transaction carries data");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == OP_LOAD && !out_valid |=> !out_valid)
    else $error("load transaction produced a result");

endmodule

bind fft_hilbert_envelope fhe_checker u_fhe_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (samples.valid),
  .in_ready     (samples.ready),
  .opcode       (samples.opcode),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .envelope     (results.envelope),
  .end_of_frame (results.end_of_frame),
  .no_data      (results.no_data)
);
`default_nettype wire
